// ===== rtl/core/vrt_pkg.sv =====
// Shared types and constants of the video raster timing register unit.
// Used by vrt_core and video_raster_timing_registers_unit; no dependencies.
`timescale 1ns / 1ps

package vrt_pkg;

	// Operation carried in tuser of the input stream
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} opcode_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_LINE_LENGTH        = 3'd0;
	localparam logic [2:0] CFG_HBLANK_FIRST       = 3'd1;
	localparam logic [2:0] CFG_HBLANK_LAST        = 3'd2;
	localparam logic [2:0] CFG_LINES_PROG         = 3'd3;
	localparam logic [2:0] CFG_LINES_INTL         = 3'd4;
	localparam logic [2:0] CFG_VBLANK_LINES_PROG  = 3'd5;
	localparam logic [2:0] CFG_VBLANK_LINES_INTL  = 3'd6;

	// Configuration reset values
	localparam logic [10:0] RST_LINE_LENGTH       = 11'd858;
	localparam logic [10:0] RST_HBLANK_FIRST      = 11'd0;
	localparam logic [10:0] RST_HBLANK_LAST       = 11'd137;
	localparam logic [9:0]  RST_LINES_PROG        = 10'd262;
	localparam logic [9:0]  RST_LINES_INTL        = 10'd525;
	localparam logic [9:0]  RST_VBLANK_LINES_PROG = 10'd22;
	localparam logic [9:0]  RST_VBLANK_LINES_INTL = 10'd22;

	// Byte register offsets
	localparam logic [3:0] REG_MODE    = 4'h0;
	localparam logic [3:0] REG_LINE_LO = 4'h2;
	localparam logic [3:0] REG_LINE_HI = 4'h3;
	localparam logic [3:0] REG_PIX_LO  = 4'h4;
	localparam logic [3:0] REG_PIX_HI  = 4'h5;
	localparam logic [3:0] REG_VBLANK  = 4'h6;
	localparam logic [3:0] REG_HBLANK  = 4'h8;
	localparam logic [3:0] REG_IRQ_CLR = 4'hA;

	// First line of the second field's blanking in interlaced mode
	localparam logic [10:0] FIELD2_START = 11'd262;

	typedef struct packed {
		logic [10:0] line_length;
		logic [10:0] hblank_first;
		logic [10:0] hblank_last;
		logic [9:0]  lines_progressive;
		logic [9:0]  lines_interlaced;
		logic [9:0]  vblank_lines_progressive;
		logic [9:0]  vblank_lines_interlaced;
	} cfg_t;

	typedef struct packed {
		logic [10:0] pixel_count;
		logic [9:0]  line_count;
		logic        interlaced;
		logic        in_hblank;
		logic        in_vblank;
		logic        irq_pending;
	} state_t;

	typedef struct packed {
		logic       irq_event;
		logic       irq_pending;
		logic       vram_access_ok;
		logic       vblank_flag;
		logic       hblank_flag;
		logic [7:0] read_data;
	} result_t;

endpackage

// ===== rtl/core/vrt_core.sv =====
// Next-state and result logic of the raster timing unit for one item.
// Depends on vrt_pkg for the configuration, state and result types.
`timescale 1ns / 1ps

module vrt_core (
	input  vrt_pkg::cfg_t    cfg,
	input  vrt_pkg::state_t  cur,
	input  vrt_pkg::opcode_t op,
	input  logic [3:0]       reg_offset,
	input  logic [7:0]       write_data,
	output vrt_pkg::state_t  nxt,
	output vrt_pkg::result_t res
);

	logic [11:0] pix_inc;
	logic [10:0] line_inc;
	logic        pix_wrap;
	logic        frame_wrap;
	logic [9:0]  frame_total;
	logic [10:0] tick_pixel;
	logic [9:0]  tick_line;
	logic [10:0] field2_end;
	logic        tick_hblank;
	logic        tick_vblank;
	logic [7:0]  rd;

	// Advance the counters for a tick and derive the blank flags from them
	always_comb begin
		pix_inc     = {1'b0, cur.pixel_count} + 12'd1;
		line_inc    = {1'b0, cur.line_count} + 11'd1;
		pix_wrap    = pix_inc >= {1'b0, cfg.line_length};
		frame_total = cur.interlaced ? cfg.lines_interlaced : cfg.lines_progressive;
		frame_wrap  = pix_wrap && (line_inc >= {1'b0, frame_total});
		tick_pixel  = pix_wrap ? 11'd0 : pix_inc[10:0];
		if (frame_wrap) begin
			tick_line = 10'd0;
		end else if (pix_wrap) begin
			tick_line = line_inc[9:0];
		end else begin
			tick_line = cur.line_count;
		end
		field2_end  = vrt_pkg::FIELD2_START + {1'b0, cfg.vblank_lines_interlaced};
		tick_hblank = (tick_pixel >= cfg.hblank_first) && (tick_pixel <= cfg.hblank_last);
		if (cur.interlaced) begin
			tick_vblank = (tick_line < cfg.vblank_lines_interlaced) ||
				(({1'b0, tick_line} >= vrt_pkg::FIELD2_START) &&
				 ({1'b0, tick_line} < field2_end));
		end else begin
			tick_vblank = tick_line < cfg.vblank_lines_progressive;
		end
	end

	// Register read map
	always_comb begin
		unique case (reg_offset)
			vrt_pkg::REG_MODE:    rd = {7'd0, cur.interlaced};
			vrt_pkg::REG_LINE_LO: rd = cur.line_count[7:0];
			vrt_pkg::REG_LINE_HI: rd = {6'd0, cur.line_count[9:8]};
			vrt_pkg::REG_PIX_LO:  rd = cur.pixel_count[7:0];
			vrt_pkg::REG_PIX_HI:  rd = {5'd0, cur.pixel_count[10:8]};
			vrt_pkg::REG_VBLANK:  rd = {7'd0, cur.in_vblank};
			vrt_pkg::REG_HBLANK:  rd = {7'd0, cur.in_hblank};
			default:              rd = 8'd0;
		endcase
	end

	// Apply the operation and form the result
	always_comb begin
		nxt           = cur;
		res.read_data = 8'd0;
		res.irq_event = 1'b0;
		unique case (op)
			vrt_pkg::OP_TICK: begin
				nxt.pixel_count = tick_pixel;
				nxt.line_count  = tick_line;
				nxt.in_hblank   = tick_hblank;
				nxt.in_vblank   = tick_vblank;
				if (frame_wrap && !cur.irq_pending) begin
					nxt.irq_pending = 1'b1;
					res.irq_event   = 1'b1;
				end
			end
			vrt_pkg::OP_READ: begin
				res.read_data = rd;
			end
			vrt_pkg::OP_WRITE: begin
				if (reg_offset == vrt_pkg::REG_MODE) begin
					nxt.interlaced = write_data[0];
				end else if (reg_offset == vrt_pkg::REG_IRQ_CLR && write_data != 8'd0) begin
					nxt.irq_pending = 1'b0;
				end
			end
			default: begin
				// unused opcode: no state change
			end
		endcase
		res.hblank_flag    = nxt.in_hblank;
		res.vblank_flag    = nxt.in_vblank;
		res.vram_access_ok = nxt.in_hblank | nxt.in_vblank;
		res.irq_pending    = nxt.irq_pending;
	end

endmodule

// ===== rtl/core/video_raster_timing_registers_unit.sv =====
// Top level of the video raster timing register unit: stream handshake,
// configuration registers, state and result register. Uses vrt_pkg and vrt_core.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one item per transfer: tuser holds the opcode (tick, register
//   read, register write), tdata the byte offset and the write byte. m_axis
//   returns exactly one result per item: read byte, blank flags, access-ok,
//   interrupt pending level and the one-shot interrupt event.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the seven timing registers;
//   an index above six is ignored. Write them only while the unit is idle.
// Timing:
//   An item is processed in the cycle it is accepted and its result is shown
//   on m_axis from the next cycle; one item per cycle while m_axis_tready is high.
//   The single output register holds the result; s_axis_tready is high while
//   the output register is empty or being taken in the same cycle.
// Stall:
//   While m_axis_tready is low a pending result holds and s_axis_tready drops,
//   so no item is lost or duplicated.
// Reset:
//   arst_n clears the counters, mode and interrupt, sets both blank flags,
//   loads the timing registers with their defaults and empties the output.

module video_raster_timing_registers_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [3:0] reg_offset, [11:4] write_data, rest zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] read_data, [8] hblank_flag, [9] vblank_flag,
	                                   // [10] vram_access_ok, [11] irq_pending,
	                                   // [12] irq_event, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	vrt_pkg::cfg_t    cfg_q;
	vrt_pkg::state_t  state_q;
	vrt_pkg::state_t  state_nxt;
	vrt_pkg::result_t res_nxt;
	vrt_pkg::result_t res_q;
	logic             out_valid_q;
	logic             in_xfer;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, res_q};

	// Write the timing registers, truncated to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_length              <= vrt_pkg::RST_LINE_LENGTH;
			cfg_q.hblank_first             <= vrt_pkg::RST_HBLANK_FIRST;
			cfg_q.hblank_last              <= vrt_pkg::RST_HBLANK_LAST;
			cfg_q.lines_progressive        <= vrt_pkg::RST_LINES_PROG;
			cfg_q.lines_interlaced         <= vrt_pkg::RST_LINES_INTL;
			cfg_q.vblank_lines_progressive <= vrt_pkg::RST_VBLANK_LINES_PROG;
			cfg_q.vblank_lines_interlaced  <= vrt_pkg::RST_VBLANK_LINES_INTL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vrt_pkg::CFG_LINE_LENGTH:       cfg_q.line_length <= cfg_data;
				vrt_pkg::CFG_HBLANK_FIRST:      cfg_q.hblank_first <= cfg_data;
				vrt_pkg::CFG_HBLANK_LAST:       cfg_q.hblank_last <= cfg_data;
				vrt_pkg::CFG_LINES_PROG:        cfg_q.lines_progressive <= cfg_data[9:0];
				vrt_pkg::CFG_LINES_INTL:        cfg_q.lines_interlaced <= cfg_data[9:0];
				vrt_pkg::CFG_VBLANK_LINES_PROG: cfg_q.vblank_lines_progressive <= cfg_data[9:0];
				vrt_pkg::CFG_VBLANK_LINES_INTL: cfg_q.vblank_lines_interlaced <= cfg_data[9:0];
				default: begin
					// index beyond the register list: drop
				end
			endcase
		end
	end

	vrt_core u_core (
		.cfg        (cfg_q),
		.cur        (state_q),
		.op         (vrt_pkg::opcode_t'(s_axis_tuser)),
		.reg_offset (s_axis_tdata[3:0]),
		.write_data (s_axis_tdata[11:4]),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Advance the state on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pixel_count <= 11'd0;
			state_q.line_count  <= 10'd0;
			state_q.interlaced  <= 1'b0;
			state_q.in_hblank   <= 1'b1;
			state_q.in_vblank   <= 1'b1;
			state_q.irq_pending <= 1'b0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until the output transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res_nxt;
		end
	end

	// An interrupt event always comes with the pending level
	a_event_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.irq_event |-> res_q.irq_pending)
		else $error("irq_event without irq_pending");

	// An interrupt event is raised only at the frame wrap
	a_event_at_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.irq_event |->
			state_q.pixel_count == 11'd0 && state_q.line_count == 10'd0)
		else $error("irq_event away from frame wrap");

	// The shown flags match the stored state they were taken from
	a_flags_track_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.hblank_flag == state_q.in_hblank &&
			res_q.vblank_flag == state_q.in_vblank &&
			res_q.irq_pending == state_q.irq_pending)
		else $error("result flags disagree with state");

endmodule
